// ===== rtl/core/sfcs_pkg.sv =====
package sfcs_pkg;

  // bus byte phases of a command frame, in frame order
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_OPC   = 3'd1,
    PH_DMY   = 3'd2,
    PH_PAR   = 3'd3,
    PH_DOUT  = 3'd4,
    PH_RET   = 3'd5,
    PH_DIDMY = 3'd6,
    PH_DIN   = 3'd7
  } phase_e;

  // word kinds on the input stream
  typedef enum logic {
    OP_START = 1'b0,
    OP_SLOT  = 1'b1
  } op_e;

  localparam int unsigned MAX_DATA_BYTES = 4096;
  localparam int unsigned CNT_W          = 13;
  localparam int unsigned NUM_CMDS       = 14;

  // input tdata layout
  localparam int unsigned IN_INSTR_LSB = 0;
  localparam int unsigned IN_PARAM_LSB = 4;
  localparam int unsigned IN_COUNT_LSB = 36;
  localparam int unsigned IN_HOST_LSB  = 49;
  localparam int unsigned IN_RX_LSB    = 57;
  localparam int unsigned IN_TDATA_W   = 72;

  // output tdata layout
  localparam int unsigned OUT_TX_BYTE_LSB = 0;
  localparam int unsigned OUT_TX_VALID    = 8;
  localparam int unsigned OUT_TOOK_HOST   = 9;
  localparam int unsigned OUT_HRX_LSB     = 10;
  localparam int unsigned OUT_HRX_VALID   = 18;
  localparam int unsigned OUT_CS          = 19;
  localparam int unsigned OUT_STATUS      = 20;
  localparam int unsigned OUT_TDATA_W     = 24;

  // opcode rom
  function automatic logic [7:0] cmd_opcode(logic [3:0] cmd);
    logic [7:0] op;
    unique case (cmd)
      4'd0:    op = 8'hFF;
      4'd1:    op = 8'h9F;
      4'd2:    op = 8'h0F;
      4'd3:    op = 8'h1F;
      4'd4:    op = 8'h06;
      4'd5:    op = 8'h04;
      4'd6:    op = 8'hA1;
      4'd7:    op = 8'hA5;
      4'd8:    op = 8'hD8;
      4'd9:    op = 8'h02;
      4'd10:   op = 8'h84;
      4'd11:   op = 8'h10;
      4'd12:   op = 8'h13;
      4'd13:   op = 8'h03;
      default: op = 8'h00;
    endcase
    return op;
  endfunction

  // phase flags: [7] dummy, [6:5] param code, [4] return, [3:2] return code,
  // [1] data out, [0] data in
  function automatic logic [7:0] cmd_flags(logic [3:0] cmd);
    logic [7:0] f;
    unique case (cmd)
      4'd1:    f = 8'h98;
      4'd2:    f = 8'h30;
      4'd3:    f = 8'h40;
      4'd6:    f = 8'h60;
      4'd7:    f = 8'h9C;
      4'd8:    f = 8'hC0;
      4'd9:    f = 8'h42;
      4'd10:   f = 8'h42;
      4'd11:   f = 8'hC0;
      4'd12:   f = 8'hC0;
      4'd13:   f = 8'h41;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

  // number of bus bytes in a phase for a given command
  function automatic logic [CNT_W-1:0] phase_len(phase_e ph, logic [7:0] f,
                                                 logic [CNT_W-1:0] dc);
    logic [CNT_W-1:0] n;
    n = '0;
    unique case (ph)
      PH_OPC:   n = CNT_W'(1);
      PH_DMY:   n = CNT_W'(f[7]);
      PH_PAR: begin
        unique case (f[6:5])
          2'd0:    n = CNT_W'(0);
          2'd1:    n = CNT_W'(1);
          2'd2:    n = CNT_W'(2);
          default: n = CNT_W'(4);
        endcase
      end
      PH_DOUT:  n = f[1] ? dc : '0;
      PH_RET: begin
        if (f[4]) begin
          unique case (f[3:2])
            2'd0:    n = CNT_W'(1);
            2'd1:    n = CNT_W'(2);
            2'd2:    n = CNT_W'(3);
            default: n = CNT_W'(32);
          endcase
        end
      end
      PH_DIDMY: n = CNT_W'(f[0]);
      PH_DIN:   n = f[0] ? dc : '0;
      default:  n = '0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/spi_flash_command_sequencer_unit.sv =====
// an accepted input word is held in the input register, its result word in the result register
// throughput: one word per cycle; the sequencer state updates in a single
//   pass between the input register and the result register
// stalls only when both registers are full and m_axis_tready is low
// reset (rst_ni low, asynchronous): idle, no frame open, both stages empty
module spi_flash_command_sequencer_unit
  import sfcs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // instruction, param_word, data_count, host_byte, bus_rx_byte, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tx_byte, tx_valid, took_host_byte, host_rx_byte, host_rx_valid,
  // chip_select, status, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // frame_done
  output logic                   m_axis_tlast
);

  // input register
  logic             in_valid_q;
  op_e              in_op_q;
  logic [3:0]       in_instr_q;
  logic [31:0]      in_param_q;
  logic [CNT_W-1:0] in_count_q;
  logic [7:0]       in_host_q;
  logic [7:0]       in_rx_q;

  // sequencer state
  phase_e           phase_q, phase_d;
  logic [3:0]       cmd_q, cmd_d;
  logic [CNT_W-1:0] pcount_q, pcount_d;
  logic [31:0]      params_q, params_d;
  logic [CNT_W-1:0] dcount_q, dcount_d;
  logic             cap_q, cap_d;

  // result register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic                   out_last_q, out_last_d;

  logic out_ready;
  logic advance;

  logic [7:0]       flags;
  logic [CNT_W-1:0] len_cur;
  logic [CNT_W-1:0] pcount_inc;
  logic             nxt_found;
  phase_e           nxt_ph;
  phase_e           ph_eff;

  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       took_host;
  logic [7:0] hrx_byte;
  logic       hrx_valid;
  logic       cs;
  logic       status;
  logic       done;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  assign flags      = cmd_flags(cmd_q);
  assign len_cur    = phase_len(phase_q, flags, dcount_q);
  assign pcount_inc = pcount_q + CNT_W'(1);

  // first non-empty phase after the current one
  always_comb begin
    nxt_found = 1'b0;
    nxt_ph    = PH_IDLE;
    for (int i = 7; i >= 2; i--) begin
      if (3'(i) > phase_q && phase_len(phase_e'(3'(i)), flags, dcount_q) != '0) begin
        nxt_found = 1'b1;
        nxt_ph    = phase_e'(3'(i));
      end
    end
  end

  // next state and result word
  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    pcount_d  = pcount_q;
    params_d  = params_q;
    dcount_d  = dcount_q;
    cap_d     = cap_q;
    ph_eff    = phase_q;
    tx_byte   = '0;
    tx_valid  = 1'b0;
    took_host = 1'b0;
    hrx_byte  = '0;
    hrx_valid = 1'b0;
    cs        = 1'b0;
    status    = 1'b0;
    done      = 1'b0;

    if (in_op_q == OP_START) begin
      if (phase_q != PH_IDLE) begin
        // busy: reject, frame keeps running
        cs     = 1'b1;
        status = 1'b1;
      end else if (in_instr_q >= 4'(NUM_CMDS)) begin
        status = 1'b1;
      end else begin
        cmd_d    = in_instr_q;
        params_d = in_param_q;
        dcount_d = (in_count_q > CNT_W'(MAX_DATA_BYTES)) ? CNT_W'(MAX_DATA_BYTES)
                                                          : in_count_q;
        phase_d  = PH_OPC;
        pcount_d = '0;
        cap_d    = 1'b0;
        tx_byte  = cmd_opcode(in_instr_q);
        tx_valid = 1'b1;
        cs       = 1'b1;
      end
    end else if (phase_q != PH_IDLE) begin
      if (cap_q) begin
        hrx_byte  = in_rx_q;
        hrx_valid = 1'b1;
      end
      if (pcount_inc < len_cur) begin
        pcount_d = pcount_inc;
      end else if (!nxt_found) begin
        phase_d  = PH_IDLE;
        pcount_d = '0;
        cap_d    = 1'b0;
        done     = 1'b1;
      end else begin
        phase_d  = nxt_ph;
        ph_eff   = nxt_ph;
        pcount_d = '0;
      end
      if (!done) begin
        tx_valid = 1'b1;
        cs       = 1'b1;
        if (ph_eff == PH_PAR) begin
          unique case (pcount_d[1:0])
            2'd0:    tx_byte = params_q[7:0];
            2'd1:    tx_byte = params_q[15:8];
            2'd2:    tx_byte = params_q[23:16];
            default: tx_byte = params_q[31:24];
          endcase
        end else if (ph_eff == PH_DOUT) begin
          tx_byte   = in_host_q;
          took_host = 1'b1;
        end
        cap_d = (ph_eff == PH_RET) || (ph_eff == PH_DIN);
      end
    end

    out_data_d = '0;
    out_data_d[OUT_TX_BYTE_LSB +: 8] = tx_byte;
    out_data_d[OUT_TX_VALID]         = tx_valid;
    out_data_d[OUT_TOOK_HOST]        = took_host;
    out_data_d[OUT_HRX_LSB +: 8]     = hrx_byte;
    out_data_d[OUT_HRX_VALID]        = hrx_valid;
    out_data_d[OUT_CS]               = cs;
    out_data_d[OUT_STATUS]           = status;
    out_last_d                       = done;
  end

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q    <= op_e'(s_axis_tuser);
      in_instr_q <= s_axis_tdata[IN_INSTR_LSB +: 4];
      in_param_q <= s_axis_tdata[IN_PARAM_LSB +: 32];
      in_count_q <= s_axis_tdata[IN_COUNT_LSB +: CNT_W];
      in_host_q  <= s_axis_tdata[IN_HOST_LSB +: 8];
      in_rx_q    <= s_axis_tdata[IN_RX_LSB +: 8];
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cmd_q    <= '0;
      pcount_q <= '0;
      params_q <= '0;
      dcount_q <= '0;
      cap_q    <= 1'b0;
    end else if (advance) begin
      phase_q  <= phase_d;
      cmd_q    <= cmd_d;
      pcount_q <= pcount_d;
      params_q <= params_d;
      dcount_q <= dcount_d;
      cap_q    <= cap_d;
    end
  end

  // result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/sfcs_checker.sv =====
module sfcs_checker
  import sfcs_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // the frame end word releases chip select and sends nothing
  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      !m_axis_tdata[OUT_CS] && !m_axis_tdata[OUT_TX_VALID] && !m_axis_tdata[OUT_STATUS])
    else $error("frame end word with chip select or transmit");

  // a rejected start moves no bus byte
  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OUT_STATUS] |->
      !m_axis_tdata[OUT_TX_VALID] && !m_axis_tdata[OUT_HRX_VALID] && !m_axis_tlast)
    else $error("rejected start carried bus data");

  // a consumed host byte is always transmitted under chip select
  a_host_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OUT_TOOK_HOST] |->
      m_axis_tdata[OUT_TX_VALID] && m_axis_tdata[OUT_CS])
    else $error("host byte taken without transmit");

endmodule

bind spi_flash_command_sequencer_unit sfcs_checker u_sfcs_checker (.*);

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfcs_pkg::*;

  // command indexes of the descriptor rom, the last two are not decoded
  typedef enum logic [3:0] {
    CMD_RESET         = 4'd0,
    CMD_READ_ID       = 4'd1,
    CMD_GET_FEATURE   = 4'd2,
    CMD_SET_FEATURE   = 4'd3,
    CMD_WRITE_EN      = 4'd4,
    CMD_WRITE_DIS     = 4'd5,
    CMD_BBM_SWAP      = 4'd6,
    CMD_READ_BBM      = 4'd7,
    CMD_BLOCK_ERASE   = 4'd8,
    CMD_PROG_LOAD     = 4'd9,
    CMD_PROG_LOAD_RND = 4'd10,
    CMD_PROG_EXEC     = 4'd11,
    CMD_PAGE_READ     = 4'd12,
    CMD_READ_DATA     = 4'd13,
    CMD_INVALID_A     = 4'd14,
    CMD_INVALID_B     = 4'd15
  } cmd_e;

  // frame layout of one command
  typedef struct packed {
    logic [7:0] opcode;
    logic       dummy;
    logic [2:0] n_param;
    logic [5:0] n_ret;
    logic       dout;
    logic       din;
  } cmd_desc_t;

  // one input word, or a marker that holds the sender until all results are back
  typedef struct {
    op_e        op;
    cmd_e       instr;
    logic [31:0] params;
    logic [12:0] count;
    logic [7:0] host;
    logic [7:0] rx;
    bit         drain;
  } seq_word_t;

  // one result word
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       took_host;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       cs;
    logic       done;
    logic       status;
  } slot_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  seq_word_t    pend_q[$];
  slot_result_t sched_q[$];
  seq_word_t    cur_word;
  int unsigned  total_words = 1;
  int unsigned  words_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  error_cnt = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;

  // sequencer model state
  phase_e       seq_phase = PH_IDLE;
  cmd_e         seq_cmd = CMD_RESET;
  int unsigned  seq_idx = 0;
  logic [31:0]  seq_params = '0;
  int unsigned  seq_count = 0;
  bit           seq_capture = 1'b0;

  spi_flash_command_sequencer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // opcode and phase layout per command
  function automatic cmd_desc_t describe(cmd_e c);
    cmd_desc_t d;
    d = '0;
    case (c)
      CMD_RESET:         d.opcode = 8'hFF;
      CMD_READ_ID:       begin d.opcode = 8'h9F; d.dummy = 1'b1; d.n_ret = 6'd3; end
      CMD_GET_FEATURE:   begin d.opcode = 8'h0F; d.n_param = 3'd1; d.n_ret = 6'd1; end
      CMD_SET_FEATURE:   begin d.opcode = 8'h1F; d.n_param = 3'd2; end
      CMD_WRITE_EN:      d.opcode = 8'h06;
      CMD_WRITE_DIS:     d.opcode = 8'h04;
      CMD_BBM_SWAP:      begin d.opcode = 8'hA1; d.n_param = 3'd4; end
      CMD_READ_BBM:      begin d.opcode = 8'hA5; d.dummy = 1'b1; d.n_ret = 6'd32; end
      CMD_BLOCK_ERASE:   begin d.opcode = 8'hD8; d.dummy = 1'b1; d.n_param = 3'd2; end
      CMD_PROG_LOAD:     begin d.opcode = 8'h02; d.n_param = 3'd2; d.dout = 1'b1; end
      CMD_PROG_LOAD_RND: begin d.opcode = 8'h84; d.n_param = 3'd2; d.dout = 1'b1; end
      CMD_PROG_EXEC:     begin d.opcode = 8'h10; d.dummy = 1'b1; d.n_param = 3'd2; end
      CMD_PAGE_READ:     begin d.opcode = 8'h13; d.dummy = 1'b1; d.n_param = 3'd2; end
      CMD_READ_DATA:     begin d.opcode = 8'h03; d.n_param = 3'd2; d.din = 1'b1; end
      default:           d = '0;
    endcase
    return d;
  endfunction

  function automatic int unsigned clamp_count(logic [12:0] cnt);
    return (cnt > MAX_DATA_BYTES) ? MAX_DATA_BYTES : int'(cnt);
  endfunction

  // bus bytes in one phase of the open frame
  function automatic int unsigned phase_span(phase_e ph);
    cmd_desc_t d;
    d = describe(seq_cmd);
    case (ph)
      PH_OPC:   return 1;
      PH_DMY:   return d.dummy;
      PH_PAR:   return d.n_param;
      PH_DOUT:  return d.dout ? seq_count : 0;
      PH_RET:   return d.n_ret;
      PH_DIDMY: return d.din;
      PH_DIN:   return d.din ? seq_count : 0;
      default:  return 0;
    endcase
  endfunction

  // step the sequencer by one accepted word and give the result word
  function automatic slot_result_t advance_sequencer(seq_word_t w);
    slot_result_t r;
    int unsigned  p;
    cmd_desc_t    d;
    r = '0;
    if (w.op == OP_START) begin
      if (seq_phase != PH_IDLE) begin
        r.cs = 1'b1;
        r.status = 1'b1;
      end else if (w.instr >= NUM_CMDS) begin
        r.status = 1'b1;
      end else begin
        seq_cmd = w.instr;
        seq_params = w.params;
        seq_count = clamp_count(w.count);
        seq_phase = PH_OPC;
        seq_idx = 0;
        seq_capture = 1'b0;
        d = describe(w.instr);
        r.tx_byte = d.opcode;
        r.tx_valid = 1'b1;
        r.cs = 1'b1;
      end
      return r;
    end
    if (seq_phase == PH_IDLE) return r;

    if (seq_capture) begin
      r.rx_byte = w.rx;
      r.rx_valid = 1'b1;
    end

    if (seq_idx + 1 < phase_span(seq_phase)) begin
      seq_idx++;
    end else begin
      // skip phases this command does not have
      p = int'(seq_phase) + 1;
      while (p <= int'(PH_DIN) && phase_span(phase_e'(p[2:0])) == 0) p++;
      if (p > int'(PH_DIN)) begin
        seq_phase = PH_IDLE;
        seq_idx = 0;
        seq_capture = 1'b0;
        r.done = 1'b1;
        return r;
      end
      seq_phase = phase_e'(p[2:0]);
      seq_idx = 0;
    end

    r.tx_valid = 1'b1;
    r.cs = 1'b1;
    if (seq_phase == PH_PAR) begin
      r.tx_byte = seq_params[(seq_idx % 4) * 8 +: 8];
    end else if (seq_phase == PH_DOUT) begin
      r.tx_byte = w.host;
      r.took_host = 1'b1;
    end
    seq_capture = (seq_phase == PH_RET) || (seq_phase == PH_DIN);
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_word(seq_word_t w);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_INSTR_LSB +: 4]     = w.instr;
    d[IN_PARAM_LSB +: 32]    = w.params;
    d[IN_COUNT_LSB +: CNT_W] = w.count;
    d[IN_HOST_LSB +: 8]      = w.host;
    d[IN_RX_LSB +: 8]        = w.rx;
    return d;
  endfunction

  function automatic slot_result_t unpack_result(logic [OUT_TDATA_W-1:0] d, logic last);
    slot_result_t r;
    r.tx_byte   = d[OUT_TX_BYTE_LSB +: 8];
    r.tx_valid  = d[OUT_TX_VALID];
    r.took_host = d[OUT_TOOK_HOST];
    r.rx_byte   = d[OUT_HRX_LSB +: 8];
    r.rx_valid  = d[OUT_HRX_VALID];
    r.cs        = d[OUT_CS];
    r.status    = d[OUT_STATUS];
    r.done      = last;
    return r;
  endfunction

  // idle chance in percent: sender light then heavy, receiver the reverse, then none
  function automatic int unsigned idle_pct(bit rx_side);
    if (words_sent < total_words * 35 / 100) return rx_side ? 79 : 23;
    if (words_sent < total_words * 70 / 100) return rx_side ? 23 : 79;
    return 0;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got_v, int unsigned want_v);
    error_cnt++;
    if (error_cnt <= 40)
      $display("mismatch: %s on result %0d, got 0x%0h, want 0x%0h",
               what, results_seen, got_v, want_v);
  endtask

  function automatic seq_word_t random_word(op_e op);
    seq_word_t w;
    w.op = op;
    w.instr = cmd_e'($urandom_range(0, 15));
    w.params = $urandom;
    w.count = 13'($urandom_range(0, 8191));
    w.host = 8'($urandom_range(0, 255));
    w.rx = 8'($urandom_range(0, 255));
    w.drain = 1'b0;
    return w;
  endfunction

  // start word plus exactly the slot words that close the frame
  task automatic add_frame(cmd_e c, logic [31:0] params, logic [12:0] cnt, int busy_pct);
    seq_word_t   w;
    cmd_desc_t   d;
    int unsigned n;
    int unsigned sat;
    d = describe(c);
    sat = clamp_count(cnt);
    n = 1 + d.dummy + d.n_param + (d.dout ? sat : 0) + d.n_ret + (d.din ? 1 + sat : 0);
    w = random_word(OP_START);
    w.instr = c;
    w.params = params;
    w.count = cnt;
    pend_q.push_back(w);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < busy_pct) pend_q.push_back(random_word(OP_START));
      pend_q.push_back(random_word(OP_SLOT));
    end
  endtask

  function automatic logic [12:0] data_count_for(cmd_e c);
    if (c == CMD_PROG_LOAD || c == CMD_PROG_LOAD_RND || c == CMD_READ_DATA) begin
      if ($urandom_range(0, 9) == 0) return 13'($urandom_range(0, 64));
      return 13'($urandom_range(0, 8));
    end
    return 13'($urandom_range(0, 8191));
  endfunction

  // input driver
  always @(posedge clk_i) begin
    logic valid_next;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      valid_next = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        sched_q.push_back(advance_sequencer(cur_word));
        words_sent <= words_sent + 1;
        valid_next = 1'b0;
      end
      if (!valid_next) begin
        if (pend_q.size() != 0 && pend_q[0].drain && sched_q.size() == 0)
          void'(pend_q.pop_front());
        if (pend_q.size() != 0 && !pend_q[0].drain &&
            $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          cur_word = pend_q.pop_front();
          s_axis_tdata <= pack_word(cur_word);
          s_axis_tuser <= cur_word.op;
          valid_next = 1'b1;
        end
      end
      s_axis_tvalid <= valid_next;
    end
  end

  // long receiver hold-off once traffic is flowing
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (!hold_done && words_sent >= 150) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor and checker
  always @(posedge clk_i) begin
    slot_result_t got;
    slot_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_result(m_axis_tdata, m_axis_tlast);
        if (sched_q.size() == 0) begin
          flag_mismatch("unexpected word", 32'(got), 0);
        end else begin
          want = sched_q.pop_front();
          if (got.tx_byte !== want.tx_byte) flag_mismatch("tx_byte", got.tx_byte, want.tx_byte);
          if (got.tx_valid !== want.tx_valid)
            flag_mismatch("tx_valid", got.tx_valid, want.tx_valid);
          if (got.took_host !== want.took_host)
            flag_mismatch("took_host_byte", got.took_host, want.took_host);
          if (got.rx_byte !== want.rx_byte)
            flag_mismatch("host_rx_byte", got.rx_byte, want.rx_byte);
          if (got.rx_valid !== want.rx_valid)
            flag_mismatch("host_rx_valid", got.rx_valid, want.rx_valid);
          if (got.cs !== want.cs) flag_mismatch("chip_select", got.cs, want.cs);
          if (got.done !== want.done) flag_mismatch("frame_done", got.done, want.done);
          if (got.status !== want.status) flag_mismatch("status", got.status, want.status);
        end
        results_seen++;
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // stimulus, reset and end of run
  initial begin
    seq_word_t   w;
    int unsigned big_words;
    int unsigned frames;
    int unsigned mark;
    bit          big_done;
    big_words = 0;
    frames = 0;
    big_done = 1'b0;

    // slot while idle, all zero fields
    w = random_word(OP_SLOT);
    w.instr = CMD_RESET;
    w.params = '0;
    w.count = '0;
    w.host = '0;
    w.rx = '0;
    pend_q.push_back(w);
    // undecoded commands
    w = random_word(OP_START);
    w.instr = CMD_INVALID_A;
    pend_q.push_back(w);
    w.instr = CMD_INVALID_B;
    w.params = '1;
    w.count = '1;
    pend_q.push_back(w);
    // opcode-only frame with a start while busy in the middle
    w = random_word(OP_START);
    w.instr = CMD_RESET;
    w.params = '0;
    w.count = '0;
    pend_q.push_back(w);
    w = random_word(OP_START);
    w.instr = CMD_WRITE_EN;
    pend_q.push_back(w);
    w = random_word(OP_SLOT);
    w.host = 8'hFF;
    w.rx = 8'hFF;
    pend_q.push_back(w);
    // zero count on data-out and data-in
    add_frame(CMD_PROG_LOAD, 32'hFFFF_FFFF, 13'd0, 0);
    add_frame(CMD_READ_DATA, 32'h0000_0000, 13'd0, 0);
    add_frame(CMD_PROG_LOAD_RND, $urandom, 13'd2, 0);
    add_frame(CMD_GET_FEATURE, $urandom, 13'd1, 0);

    // random part: mostly well-formed frames, some noise, periodic drains
    while (pend_q.size() - big_words < 900) begin
      if (!big_done && pend_q.size() >= 400) begin
        // two long frames with saturating counts
        mark = pend_q.size();
        add_frame(CMD_PROG_LOAD, $urandom, 13'h1FFF, 0);
        add_frame(CMD_READ_DATA, $urandom, 13'($urandom_range(4097, 8191)), 0);
        big_words = pend_q.size() - mark;
        big_done = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) begin
        w = random_word(op_e'($urandom_range(0, 1)));
        w.count = data_count_for(w.instr);
        pend_q.push_back(w);
      end else begin
        w.instr = cmd_e'($urandom_range(0, NUM_CMDS - 1));
        add_frame(w.instr, $urandom, data_count_for(w.instr), 4);
        frames++;
        if (frames % 12 == 0) begin
          w = random_word(OP_SLOT);
          w.drain = 1'b1;
          pend_q.push_back(w);
        end
      end
    end

    total_words = 0;
    foreach (pend_q[i]) if (!pend_q[i].drain) total_words++;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || s_axis_tvalid || sched_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

endmodule
